### hdl/dep_pkg.sv
`timescale 1ns / 1ps

package dep_pkg;

  localparam int DataW       = 32;
  localparam int CmdW        = 2;
  localparam int EntryCountW = 7;
  localparam int CapacityDef = 64;

  // command codes
  localparam logic [CmdW-1:0] CMD_INSERT  = 2'd0;
  localparam logic [CmdW-1:0] CMD_DEL_MAX = 2'd1;
  localparam logic [CmdW-1:0] CMD_DEL_MIN = 2'd2;
  localparam logic [CmdW-1:0] CMD_CLEAR   = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic apply;  // execute the command on the item being accepted
    logic load;   // capture the post-op view into the output register
  } dep_ctrl_t;

endpackage

### hdl/dep_controller.sv
`timescale 1ns / 1ps

module dep_controller
  import dep_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dep_ctrl_t ctrl_o
);

  localparam logic StIdle   = 1'b0;
  localparam logic StResult = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    ctrl_o.apply = (state_q == StIdle) && in_valid_i;
    ctrl_o.load  = (state_q == StResult) && (!out_valid_q || !out_stall_i);
    state_d      = state_q;
    case (state_q)
      StIdle: begin
        if (ctrl_o.apply) state_d = StResult;
      end
      StResult: begin
        if (ctrl_o.load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    out_valid_d = ctrl_o.load || (out_valid_q && out_stall_i);
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hdl/dep_datapath.sv
`timescale 1ns / 1ps

module dep_datapath
  import dep_pkg::*;
#(
  parameter int CAPACITY = CapacityDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dep_ctrl_t                     ctrl_i,
  input  logic        [CmdW-1:0]        command_i,
  input  logic signed [DataW-1:0]       value_i,
  output logic signed [DataW-1:0]       max_value_o,
  output logic signed [DataW-1:0]       min_value_o,
  output logic        [EntryCountW-1:0] entry_count_o,
  output logic                          is_empty_o,
  output logic                          insert_dropped_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int ExtW = CntW + EntryCountW;

  logic signed [DataW-1:0] cells_q [CAPACITY];
  logic signed [DataW-1:0] ins_val [CAPACITY];
  logic [CAPACITY-1:0]     live;
  logic [CAPACITY-1:0]     gt;
  logic [CAPACITY-1:0]     last;
  logic [CntW-1:0]         count_q, count_d;
  logic                    full;
  logic                    drop_q;
  logic signed [DataW-1:0] sel_max;
  logic [ExtW-1:0]         cnt_ext;

  logic signed [DataW-1:0] max_q, min_q;
  logic [EntryCountW-1:0]  cnt_out_q;
  logic                    empty_q, drop_out_q;

  assign full = (count_q == CntW'(CAPACITY));

  // per-cell compare against the incoming value; insert lands after equals
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign live[i] = (count_q > CntW'(i));
    assign gt[i]   = live[i] && (cells_q[i] > value_i);
    assign last[i] = (count_q == CntW'(i + 1));

    if (i == 0) begin : g_head
      assign ins_val[i] = (live[i] && !gt[i]) ? cells_q[i] : value_i;
    end else begin : g_body
      assign ins_val[i] = (live[i] && !gt[i]) ? cells_q[i] :
                          (gt[i-1] ? cells_q[i-1] : value_i);
    end
  end

  // all cells shift in parallel: up on insert, down on delete min
  always_ff @(posedge clk_i) begin
    if (ctrl_i.apply) begin
      case (command_i)
        CMD_INSERT: begin
          if (!full) begin
            for (int i = 0; i < CAPACITY; i++) cells_q[i] <= ins_val[i];
          end
        end
        CMD_DEL_MIN: begin
          for (int i = 0; i < CAPACITY - 1; i++) cells_q[i] <= cells_q[i+1];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    case (command_i)
      CMD_INSERT:  if (!full) count_d = count_q + CntW'(1);
      CMD_DEL_MAX: if (count_q != '0) count_d = count_q - CntW'(1);
      CMD_DEL_MIN: if (count_q != '0) count_d = count_q - CntW'(1);
      CMD_CLEAR:   count_d = '0;
      default:     count_d = count_q;
    endcase
  end

  // top entry select: one-hot on count, zero when empty
  always_comb begin
    sel_max = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      sel_max = sel_max | (cells_q[k] & {DataW{last[k]}});
    end
  end

  assign cnt_ext = ExtW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
    end else if (ctrl_i.apply) begin
      count_q <= count_d;
      drop_q  <= (command_i == CMD_INSERT) && full;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      max_q      <= sel_max;
      min_q      <= (count_q == '0) ? '0 : cells_q[0];
      cnt_out_q  <= cnt_ext[EntryCountW-1:0];
      empty_q    <= (count_q == '0);
      drop_out_q <= drop_q;
    end
  end

  assign max_value_o      = max_q;
  assign min_value_o      = min_q;
  assign entry_count_o    = cnt_out_q;
  assign is_empty_o       = empty_q;
  assign insert_dropped_o = drop_out_q;

endmodule

### hdl/double_ended_priority_queue.sv
`timescale 1ns / 1ps
// Double-ended priority queue, sorted cell chain.
// Output: the result register loads in the result state that follows the accept, later
//   while the previous result is still held by the receiver.
// Pacing: no new item is accepted until the previous result has loaded; the controller
//   runs idle then result per command, every cell shifts in parallel in the accept cycle.
// Reset: async active low; clears count and handshake state, cells need no clear.

module double_ended_priority_queue
  import dep_pkg::*;
#(
  parameter int CAPACITY = CapacityDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic        [CmdW-1:0]        command_i,
  input  logic signed [DataW-1:0]       value_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [DataW-1:0]       max_value_o,
  output logic signed [DataW-1:0]       min_value_o,
  output logic        [EntryCountW-1:0] entry_count_o,
  output logic                          is_empty_o,
  output logic                          insert_dropped_o
);

  dep_ctrl_t ctrl;

  // Controller: idle -> result. The command executes on the accept edge;
  // the result state waits until the output register is free to load.
  dep_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  // Datapath: ascending cell chain plus count. Insert compares every cell
  // against the value at once and shifts the upper part up one slot;
  // delete min shifts everything down; delete max and clear only touch count.
  dep_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .command_i        (command_i),
    .value_i          (value_i),
    .max_value_o      (max_value_o),
    .min_value_o      (min_value_o),
    .entry_count_o    (entry_count_o),
    .is_empty_o       (is_empty_o),
    .insert_dropped_o (insert_dropped_o)
  );

  // an accepted item blocks the input for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken twice in a row");

  // empty queue reports zero extremes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_empty_o) |-> (max_value_o == '0 && min_value_o == '0))
    else $error("empty queue shows nonzero extremes");

  // a dropped insert means the queue was full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && insert_dropped_o) |-> !is_empty_o)
    else $error("insert dropped on empty queue");

  // chain order: max never below min
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_empty_o) |-> (max_value_o >= min_value_o))
    else $error("max below min");

endmodule
